// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion helpers; every property is sampled on clk with arst_n low
// disabling the check.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(label, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, prop)
`define ASSERT_NEVER(label, cond)
`endif
`endif

// ----- rtl/core/slba_pkg.sv -----
// ----------------------------------------------------------------------------
// slba_pkg
// Shared types, widths and the bucket range table of the log band averager.
// ----------------------------------------------------------------------------
package slba_pkg;

	localparam int DATA_WIDTH      = 32;
	localparam int MAG_W           = 32;
	localparam int NUM_BUCKETS_DEF = 32;
	localparam int MAG_DEPTH_DEF   = 512;
	localparam int STORED_BINS     = 372;
	localparam int CNT_W           = 10;
	localparam int BIN_W           = 9;
	localparam int BCNT_W          = 7;
	localparam int SUM_W           = MAG_W + BCNT_W;
	localparam int REM_W           = MAG_W + 2;
	localparam logic [3:0] SHIFT_RESET = 4'd10;
	localparam logic [0:0] REG_SIZE_SHIFT = 1'b0;

	localparam logic [BIN_W-1:0] BAND_LO [32] = '{
		9'd0, 9'd0, 9'd0, 9'd0, 9'd1, 9'd1, 9'd1, 9'd1,
		9'd2, 9'd3, 9'd3, 9'd4, 9'd5, 9'd7, 9'd8, 9'd10,
		9'd13, 9'd16, 9'd19, 9'd24, 9'd30, 9'd37, 9'd45, 9'd56,
		9'd69, 9'd86, 9'd106, 9'd130, 9'd161, 9'd198, 9'd244, 9'd301
	};
	localparam logic [BIN_W-1:0] BAND_HI [32] = '{
		9'd0, 9'd0, 9'd0, 9'd1, 9'd1, 9'd1, 9'd1, 9'd2,
		9'd3, 9'd3, 9'd4, 9'd5, 9'd7, 9'd8, 9'd10, 9'd13,
		9'd16, 9'd19, 9'd24, 9'd30, 9'd37, 9'd45, 9'd56, 9'd69,
		9'd86, 9'd106, 9'd130, 9'd161, 9'd198, 9'd244, 9'd301, 9'd371
	};

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SQ,
		ST_SUM,
		ST_ROOT,
		ST_STORE,
		ST_WALK,
		ST_DRAIN,
		ST_DIV,
		ST_EMIT
	} state_t;

	function automatic logic [BCNT_W-1:0] band_count(input logic [4:0] k);
		logic [BIN_W-1:0] d;
		d = BAND_HI[k] - BAND_LO[k];
		return BCNT_W'(d) + BCNT_W'(1);
	endfunction

endpackage

// ----- rtl/core/spectrum_log_bucket_averager.sv -----
// ----------------------------------------------------------------------------
// spectrum_log_bucket_averager
// FFT bin magnitude store with per-frame log band averaging.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): one complex FFT bin per item, signed
//   Q15.16 real and imaginary parts; bin_last closes the frame.
//   Each bin goes through capture, square (one 32x32 multiplier per
//   part), sum, 32 iterations of a one-bit-per-cycle square root, and a
//   write into the magnitude RAM. Bins at position 372 and up are dropped.
//   On a last bin the block walks the bucket table: per bucket it reads the
//   RAM one bin per cycle, then runs a restoring divider, then loads the
//   output register.
//   Output channel (out_valid/out_ready): 32 bucket items in index order,
//   bucket_last on the final one. The walk stalls while the output register
//   still holds an untaken item; the last item may wait while new bins flow.
//   Reset: size_shift returns to 10, the bin counter to zero, and a clearing
//   pass writes zero to all MAG_DEPTH RAM entries while in_ready stays low;
//   APB writes are taken throughout.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module spectrum_log_bucket_averager
	import slba_pkg::*;
#(
	parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
	parameter int MAG_DEPTH   = MAG_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [2:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [DATA_WIDTH-1:0] bin_real,
	input  logic signed [DATA_WIDTH-1:0] bin_imag,
	input  logic                         bin_last,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [4:0]                   bucket_index,
	output logic [MAG_W-1:0]             bucket_average,
	output logic                         bucket_last
);

	localparam int AW = $clog2(MAG_DEPTH);
	localparam logic [4:0] LAST_K = 5'(NUM_BUCKETS - 1);
	localparam logic [AW-1:0] CLR_LAST = AW'(MAG_DEPTH - 1);
	localparam logic [5:0] DIV_LAST = 6'(SUM_W - 1);
	localparam logic [CNT_W-1:0] CNT_MAX = '1;

	// Configuration register
	logic [3:0] size_shift_q;
	logic       cfg_we;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_SIZE_SHIFT);
	assign prdata = (paddr[2] == REG_SIZE_SHIFT) ? {28'd0, size_shift_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_shift_q <= SHIFT_RESET;
		end else if (cfg_we) begin
			size_shift_q <= pwdata[3:0];
		end
	end

	// Magnitude RAM
	logic [MAG_W-1:0] mem [MAG_DEPTH];
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	logic [MAG_W-1:0] mem_wdata;
	logic             mem_re;
	logic [AW-1:0]    mem_raddr;
	logic [MAG_W-1:0] mem_rdata;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			mem_rdata <= mem[mem_raddr];
		end
	end

	// Control and datapath state
	state_t              state_q, state_d;
	logic [AW-1:0]       clr_q;
	logic [CNT_W-1:0]    bin_cnt_q;
	logic                last_q;
	logic [MAG_W-1:0]    are_q, aim_q;
	logic [2*MAG_W-1:0]  pre_q, pim_q;
	logic [2*MAG_W-1:0]  x_q;
	logic [REM_W-1:0]    rem_q;
	logic [MAG_W-1:0]    root_q;
	logic [5:0]          step_q;
	logic [4:0]          k_q;
	logic [BIN_W-1:0]    j_q;
	logic                rv_s1;
	logic [SUM_W-1:0]    acc_q;
	logic [BCNT_W:0]     drem_q;
	logic                out_valid_q;
	logic [4:0]          out_idx_q;
	logic [MAG_W-1:0]    out_avg_q;
	logic                out_last_q;

	// Square root step: bring down two bits, try subtracting 4*root+1
	logic [REM_W+1:0] rem_sh, trial;
	logic             root_ge;
	assign rem_sh  = {rem_q, x_q[2*MAG_W-1 -: 2]};
	assign trial   = {2'b00, root_q, 2'b01};
	assign root_ge = rem_sh >= trial;

	// Divider step: bring down one dividend bit, try subtracting the count
	logic [BCNT_W:0]    dcnt;
	logic [BCNT_W+1:0]  dsh;
	logic               div_ge;
	assign dcnt   = {1'b0, band_count(k_q)};
	assign dsh    = {drem_q, acc_q[SUM_W-1]};
	assign div_ge = dsh >= {1'b0, dcnt};

	logic out_free;
	assign out_free = !out_valid_q || out_ready;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: if (clr_q == CLR_LAST) state_d = ST_IDLE;
			ST_IDLE:  if (in_valid) state_d = ST_SQ;
			ST_SQ:    state_d = ST_SUM;
			ST_SUM:   state_d = ST_ROOT;
			ST_ROOT:  if (step_q == 6'(MAG_W - 1)) state_d = ST_STORE;
			ST_STORE: state_d = last_q ? ST_WALK : ST_IDLE;
			ST_WALK:  if (j_q == BAND_HI[k_q]) state_d = ST_DRAIN;
			ST_DRAIN: state_d = ST_DIV;
			ST_DIV:   if (step_q == DIV_LAST) state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free) begin
					state_d = (k_q == LAST_K) ? ST_IDLE : ST_WALK;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	// RAM port control: clearing sweep, bin store, bucket walk reads
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = '0;
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
		end else if (state_q == ST_STORE && bin_cnt_q < CNT_W'(STORED_BINS)) begin
			mem_we    = 1'b1;
			mem_waddr = AW'(bin_cnt_q);
			mem_wdata = root_q >> size_shift_q;
		end
	end

	assign mem_re    = (state_q == ST_WALK);
	assign mem_raddr = AW'(j_q);

	// Control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			bin_cnt_q <= '0;
			rv_s1     <= 1'b0;
			step_q    <= '0;
			k_q       <= '0;
		end else begin
			rv_s1 <= (state_q == ST_WALK);
			unique case (state_q)
				ST_CLEAR: clr_q <= clr_q + AW'(1);
				ST_SUM:   step_q <= '0;
				ST_ROOT:  step_q <= step_q + 6'd1;
				ST_STORE: begin
					k_q <= '0;
					if (last_q) begin
						bin_cnt_q <= '0;
					end else if (bin_cnt_q != CNT_MAX) begin
						bin_cnt_q <= bin_cnt_q + CNT_W'(1);
					end
				end
				ST_DRAIN: step_q <= '0;
				ST_DIV:   step_q <= step_q + 6'd1;
				ST_EMIT:  if (out_free) k_q <= k_q + 5'd1;
				default: ;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				are_q  <= bin_real[DATA_WIDTH-1] ? MAG_W'(~bin_real + 1'b1) : MAG_W'(bin_real);
				aim_q  <= bin_imag[DATA_WIDTH-1] ? MAG_W'(~bin_imag + 1'b1) : MAG_W'(bin_imag);
				last_q <= bin_last;
			end
			ST_SQ: begin
				pre_q <= are_q * are_q;
				pim_q <= aim_q * aim_q;
			end
			ST_SUM: begin
				x_q    <= pre_q + pim_q;
				rem_q  <= '0;
				root_q <= '0;
			end
			ST_ROOT: begin
				x_q    <= {x_q[2*MAG_W-3:0], 2'b00};
				rem_q  <= root_ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
				root_q <= {root_q[MAG_W-2:0], root_ge};
			end
			ST_STORE: begin
				j_q   <= BAND_LO[5'd0];
				acc_q <= '0;
			end
			ST_WALK: begin
				j_q <= j_q + BIN_W'(1);
			end
			ST_DRAIN: begin
				drem_q <= '0;
			end
			ST_DIV: begin
				drem_q <= div_ge ? (BCNT_W+1)'(dsh - {1'b0, dcnt}) : dsh[BCNT_W:0];
				acc_q  <= {acc_q[SUM_W-2:0], div_ge};
			end
			ST_EMIT: begin
				if (out_free) begin
					j_q   <= BAND_LO[k_q + 5'd1];
					acc_q <= '0;
				end
			end
			default: ;
		endcase
		// Accumulate RAM data in the cycle after each walk read
		if (rv_s1) begin
			acc_q <= acc_q + SUM_W'(mem_rdata);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			out_idx_q  <= k_q;
			out_avg_q  <= acc_q[MAG_W-1:0];
			out_last_q <= (k_q == LAST_K);
		end
	end

	assign out_valid      = out_valid_q;
	assign bucket_index   = out_idx_q;
	assign bucket_average = out_avg_q;
	assign bucket_last    = out_last_q;

	// Assertions
	`ASSERT_NEVER(a_no_write_in_walk, mem_we && (state_q == ST_WALK || state_q == ST_DRAIN))
	`ASSERT_CLK(a_last_index, out_valid && bucket_last |-> bucket_index == LAST_K)
	`ASSERT_NEVER(a_no_read_in_div, rv_s1 && state_q == ST_DIV)

endmodule
